@@ rtl/lbfp_pkg.sv @@
// shared types, operation codes and constants of the lsb-first bit field packer
// no dependencies; used by every module of the block but lbfp_fifo
package lbfp_pkg;

   localparam int WORD_BITS  = 32;
   localparam int WORD_BYTES = 4;

   // depths of the command queue and of the result queue
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   localparam logic [15:0] BUF_SIZE_RESET = 16'd1472;

   // operation codes on the input channel
   localparam logic [1:0] OP_PUT     = 2'd0;
   localparam logic [1:0] OP_FLUSH   = 2'd1;
   localparam logic [1:0] OP_RESTART = 2'd2;

   // register index, taken from address bit 2
   localparam logic REG_BUF_SIZE = 1'b0;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] field_value;
      logic [5:0]  field_width;
   } req_type;

   typedef struct packed {
      logic [31:0] word_out;
      logic        word_valid;
      logic        error;
      logic [15:0] bytes_used;
   } rsp_type;

   typedef enum logic [1:0] {
      KIND_PUT     = 2'd0,
      KIND_FLUSH   = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   // classified command handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic        width_bad;
      logic [5:0]  width;
      logic [3:0]  room_bytes;
      logic [31:0] value;
   } cmd_type;

endpackage

@@ rtl/lbfp_fifo.sv @@
// small first-in first-out queue of registers
// no package dependency; instanced by the top level for commands and results
module lbfp_fifo #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/lbfp_front.sv @@
// front stage: accepts input items, decodes the operation and masks the value
// depends on lbfp_pkg; feeds the command queue
module lbfp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lbfp_pkg::req_type req,
   output logic             full,
   output logic             cmd_valid,
   output lbfp_pkg::cmd_type cmd,
   input  logic             cmd_ready
);

   logic              valid_ff, valid_in;
   lbfp_pkg::cmd_type cmd_ff;
   lbfp_pkg::cmd_type cmd_in;
   logic              take;
   logic [31:0]       mask;

   assign full      = valid_ff && !cmd_ready;
   assign take      = push && !full;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      mask = req.field_width[5] ? 32'hFFFF_FFFF
                                : ((32'd1 << req.field_width[4:0]) - 32'd1);
      cmd_in.width      = req.field_width;
      cmd_in.width_bad  = req.field_width > 6'(lbfp_pkg::WORD_BITS);
      cmd_in.room_bytes = {1'b0, req.field_width[5:3]} + 4'd1;
      cmd_in.value      = req.field_value & mask;
      unique case (req.operation)
         lbfp_pkg::OP_PUT:     cmd_in.kind = lbfp_pkg::KIND_PUT;
         lbfp_pkg::OP_FLUSH:   cmd_in.kind = lbfp_pkg::KIND_FLUSH;
         lbfp_pkg::OP_RESTART: cmd_in.kind = lbfp_pkg::KIND_RESTART;
         default:              cmd_in.kind = lbfp_pkg::KIND_NONE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (cmd_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

@@ rtl/lbfp_back.sv @@
// back stage: holds the accumulator and byte count and executes one command a cycle when a
// command waits and the result queue has room; depends on lbfp_pkg; reads the command queue, writes the result queue
module lbfp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic [15:0]       buf_size,
   input  logic              cmd_empty,
   input  lbfp_pkg::cmd_type cmd,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output lbfp_pkg::rsp_type rsp
);

   logic [31:0] acc_ff, acc_in;
   logic [4:0]  pend_ff, pend_in;
   logic [15:0] count_ff, count_in;
   logic        fire;
   logic [16:0] need_put, need_word;
   logic        fits_put, fits_word;
   logic [5:0]  total;
   logic [63:0] merged;

   assign fire     = !cmd_empty && !rsp_full;
   assign cmd_pop  = fire;
   assign rsp_push = fire;

   always_comb begin
      need_put  = {1'b0, count_ff} + {13'd0, cmd.room_bytes};
      need_word = {1'b0, count_ff} + 17'(lbfp_pkg::WORD_BYTES);
      fits_put  = need_put <= {1'b0, buf_size};
      fits_word = need_word <= {1'b0, buf_size};
      total     = {1'b0, pend_ff} + cmd.width;
      merged    = ({32'd0, cmd.value} << pend_ff) | {32'd0, acc_ff};

      acc_in  = acc_ff;
      pend_in = pend_ff;
      count_in = count_ff;
      rsp.word_out   = '0;
      rsp.word_valid = 1'b0;
      rsp.error      = 1'b0;

      unique case (cmd.kind)
         lbfp_pkg::KIND_PUT: begin
            if (cmd.width_bad || !fits_put || (total[5] && !fits_word)) begin
               rsp.error = 1'b1;
            end else begin
               // a word leaves at 32 bits; pending count wraps modulo 32 either way
               pend_in = total[4:0];
               if (total[5]) begin
                  rsp.word_out   = merged[31:0];
                  rsp.word_valid = 1'b1;
                  count_in       = count_ff + 16'(lbfp_pkg::WORD_BYTES);
                  acc_in         = merged[63:32];
               end else begin
                  acc_in = merged[31:0];
               end
            end
         end
         lbfp_pkg::KIND_FLUSH: begin
            if (pend_ff != '0) begin
               if (!fits_word) begin
                  rsp.error = 1'b1;
               end else begin
                  rsp.word_out   = acc_ff;
                  rsp.word_valid = 1'b1;
                  count_in       = count_ff + 16'(lbfp_pkg::WORD_BYTES);
                  acc_in         = '0;
                  pend_in        = '0;
               end
            end else begin
               acc_in = '0;
            end
         end
         lbfp_pkg::KIND_RESTART: begin
            acc_in   = '0;
            pend_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
      rsp.bytes_used = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         pend_ff  <= '0;
         count_ff <= '0;
      end else if (fire) begin
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ rtl/lsb_first_bit_field_packer_top.sv @@
// lsb-first bit field packer: one item per cycle sustained while results are popped,
// one result per item; a result reaches the result ports through the front register,
// the command queue and the back stage, which writes the result queue
// the back stage's update of accumulator and byte count per command sets the rate
// synchronous active-high reset clears queues, accumulator, pending bits and byte count,
// and sets the buffer size register to 1472
module lsb_first_bit_field_packer_top #(
   parameter int CMD_DEPTH = lbfp_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = lbfp_pkg::RSP_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  lbfp_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output lbfp_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [15:0]       buf_size_ff, buf_size_in;
   logic              csr_wr;
   logic              front_valid, front_ready;
   lbfp_pkg::cmd_type front_cmd;
   logic              cmd_full, cmd_empty, cmd_pop;
   lbfp_pkg::cmd_type cmd_head;
   logic              rsp_full, rsp_push;
   lbfp_pkg::rsp_type back_rsp;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == lbfp_pkg::REG_BUF_SIZE);
   assign buf_size_in = csr_wr ? csr_pwdata[15:0] : buf_size_ff;
   assign csr_prdata  = (csr_paddr[2] == lbfp_pkg::REG_BUF_SIZE) ? {16'd0, buf_size_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_size_ff <= lbfp_pkg::BUF_SIZE_RESET;
      end else begin
         buf_size_ff <= buf_size_in;
      end
   end

   lbfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .req       (req_data),
      .full      (req_full),
      .cmd_valid (front_valid),
      .cmd       (front_cmd),
      .cmd_ready (front_ready)
   );

   assign front_ready = !cmd_full;

   lbfp_fifo #(
      .WIDTH ($bits(lbfp_pkg::cmd_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head),
      .empty     (cmd_empty)
   );

   lbfp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .buf_size  (buf_size_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   lbfp_fifo #(
      .WIDTH ($bits(lbfp_pkg::rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

@@ rtl/lbfp_checker.sv @@
// port-level checks of the bit field packer, bound to the top level
// depends on lbfp_pkg and lsb_first_bit_field_packer_top
module lbfp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input lbfp_pkg::rsp_type rsp_data
);

   // queues come out of reset empty and able to take an item
   a_reset_idle: assert property (@(posedge clock) reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_word_no_error: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.word_valid && rsp_data.error))
      else $error("word emitted on a rejected item");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.word_valid) |-> (rsp_data.word_out == '0))
      else $error("word bits set without a word");

   // byte count only grows by whole words or clears
   a_count_aligned: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.bytes_used[1:0] == 2'd0))
      else $error("byte count not word aligned");

endmodule

bind lsb_first_bit_field_packer_top lbfp_checker u_lbfp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_data  (rsp_data)
);
